// File: src/frba_pkg.sv
// Package for the fenced ring buffer allocator: item types, codes and defaults.
package frba_pkg;

  // Default configuration of the block.
  localparam int MARKER_DEPTH_DEF = 16;
  localparam int OFFSET_WIDTH_DEF = 32;

  // Register values after reset.
  localparam logic [63:0] RST_BUFFER_SIZE = 64'd65536;
  localparam logic [63:0] RST_FIXED_SIZE  = 64'd0;

  // Field widths fixed by the interface.
  localparam int SIZE_W  = 32;
  localparam int FENCE_W = 64;
  localparam int CFG_W   = 32;

  // Configuration register indexes.
  localparam logic CFG_BUFFER_SIZE      = 1'b0;
  localparam logic CFG_FIXED_BLOCK_SIZE = 1'b1;

  // Request codes.
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_MARK  = 1'b1;

  // Result kinds.
  localparam logic [1:0] KIND_WAIT  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_MARK  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_MEM  = 2'd1;
  localparam logic [1:0] ST_Q_FULL  = 2'd2;
  localparam logic [1:0] ST_SKIPPED = 2'd3;

  typedef struct packed {
    logic               action;
    logic [SIZE_W-1:0]  request_size;
    logic [FENCE_W-1:0] frame_fence;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        block_offset;
    logic [FENCE_W-1:0] wait_fence;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // Build one result item.
  function automatic out_item_t make_out(logic [1:0] kind, logic [31:0] off,
                                         logic [FENCE_W-1:0] fence,
                                         logic [1:0] status, logic last);
    out_item_t o;
    o.kind         = kind;
    o.block_offset = off;
    o.wait_fence   = fence;
    o.status       = status;
    o.last         = last;
    return o;
  endfunction

endpackage

// File: src/frba_marker_mem.sv
// Frame marker store: one write port, one read port, registered read data.
module frba_marker_mem import frba_pkg::*; #(
  parameter int DEPTH = MARKER_DEPTH_DEF,
  parameter int WIDTH = OFFSET_WIDTH_DEF + FENCE_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Store a marker
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: src/frba_seq.sv
// Allocation sequencer: ring pointers, marker queue control and result register.
module frba_seq import frba_pkg::*; #(
  parameter int MARKER_DEPTH = MARKER_DEPTH_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  in_item_t                in_item,
  input  logic [OFFSET_WIDTH-1:0] buf_size,
  input  logic [OFFSET_WIDTH-1:0] fixed_size,
  output logic                    out_valid,
  input  logic                    out_ready,
  output out_item_t               out_item
);

  localparam int OW   = OFFSET_WIDTH;
  localparam int MD   = MARKER_DEPTH;
  localparam int PW   = $clog2(MD);
  localparam int CNTW = $clog2(MD + 1);
  localparam int CW   = (OW > SIZE_W) ? OW : SIZE_W;
  localparam int MW   = OW + FENCE_W;
  localparam logic [OW-1:0] FREE_RST = OW'(RST_BUFFER_SIZE - RST_FIXED_SIZE);
  localparam logic [OW-1:0] FIX_RST  = OW'(RST_FIXED_SIZE);

  typedef enum logic [3:0] {
    S_IDLE, S_MARK, S_ALLOC, S_TOP, S_ENDFIT, S_EQ, S_LT, S_LTFIT, S_END,
    S_POP_RD, S_POP_WAIT
  } state_t;

  state_t          state_r;
  in_item_t        item_r;
  logic [OW-1:0]   head_r, tail_r, free_r;
  logic            moved_r, popped_r, ret_lt_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] cnt_r;
  logic            out_valid_r;
  out_item_t       out_item_r;

  logic [CW-1:0]   size_ext, free_ext, tail_ext;
  logic [OW-1:0]   size_ow, end_space, wrap_free;
  logic            fits, out_free, q_empty, q_full;
  logic            out_set, out_load;
  logic [PW:0]     wsum;
  logic [PW-1:0]   wr_ptr, rd_ptr_inc;
  logic            mem_wr_en, mem_rd_en;
  logic [MW-1:0]   mem_rd_data;
  logic [OW-1:0]   pop_off;

  // Compare request size against the free count at the wider of both widths
  assign size_ext  = CW'(item_r.request_size);
  assign free_ext  = CW'(free_r);
  assign tail_ext  = CW'(tail_r);
  assign size_ow   = size_ext[OW-1:0];
  assign fits      = (size_ext <= free_ext);
  assign end_space = (tail_r >= buf_size) ? '0 : buf_size - tail_r;
  assign wrap_free = (head_r >= fixed_size) ? head_r - fixed_size : '0;
  assign out_free  = !out_valid_r || out_ready;
  assign q_empty   = (cnt_r == '0);
  assign q_full    = (cnt_r == CNTW'(MD));

  // Flag the states that load a result item this cycle
  always_comb begin
    unique case (state_r)
      S_MARK:            out_set = 1'b1;
      S_ALLOC, S_ENDFIT: out_set = fits;
      S_EQ:              out_set = (head_r == tail_r) && q_empty;
      S_LTFIT:           out_set = fits || q_empty;
      S_END:             out_set = !popped_r;
      S_POP_WAIT:        out_set = 1'b1;
      default:           out_set = 1'b0;
    endcase
  end

  assign out_load = out_free && out_set;

  // Write slot of the next marker, modulo the queue depth
  assign wsum   = {1'b0, rd_ptr_r} + (PW + 1)'(cnt_r);
  assign wr_ptr = (wsum >= (PW + 1)'(MD)) ? PW'(wsum - (PW + 1)'(MD)) : wsum[PW-1:0];
  assign rd_ptr_inc = (rd_ptr_r == PW'(MD - 1)) ? '0 : rd_ptr_r + 1'b1;

  assign mem_wr_en = (state_r == S_MARK) && out_free && moved_r && !q_full;
  assign mem_rd_en = (state_r == S_POP_RD);
  assign pop_off   = mem_rd_data[MW-1:FENCE_W];

  frba_marker_mem #(
    .DEPTH (MD),
    .WIDTH (MW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (wr_ptr),
    .wr_data ({tail_r, item_r.frame_fence}),
    .rd_en   (mem_rd_en),
    .rd_addr (rd_ptr_r),
    .rd_data (mem_rd_data)
  );

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Sequencer: state, ring pointers, queue control and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= FIX_RST;
      tail_r      <= FIX_RST;
      free_r      <= FREE_RST;
      moved_r     <= 1'b0;
      popped_r    <= 1'b0;
      ret_lt_r    <= 1'b0;
      rd_ptr_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == S_IDLE) begin
        if (in_valid) begin
          item_r  <= in_item;
          state_r <= (in_item.action == ACT_MARK) ? S_MARK : S_ALLOC;
        end
      end else if (out_free) begin
        unique case (state_r)
          S_MARK: begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (!moved_r) begin
              out_item_r <= make_out(KIND_MARK, '0, '0, ST_SKIPPED, 1'b1);
            end else if (q_full) begin
              out_item_r <= make_out(KIND_MARK, '0, '0, ST_Q_FULL, 1'b1);
            end else begin
              cnt_r      <= cnt_r + 1'b1;
              moved_r    <= 1'b0;
              out_item_r <= make_out(KIND_MARK, '0, '0, ST_OK, 1'b1);
            end
          end
          S_ALLOC: begin
            moved_r <= 1'b1;
            if (fits) begin
              tail_r      <= tail_r + size_ow;
              free_r      <= free_r - size_ow;
              out_valid_r <= 1'b1;
              out_item_r  <= make_out(KIND_ALLOC, tail_ext[31:0], '0, ST_OK, 1'b1);
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_TOP;
            end
          end
          S_TOP: begin
            popped_r <= 1'b0;
            if (tail_r > head_r) begin
              free_r  <= end_space;
              state_r <= S_ENDFIT;
            end else begin
              state_r <= S_EQ;
            end
          end
          S_ENDFIT: begin
            if (fits) begin
              tail_r      <= tail_r + size_ow;
              free_r      <= free_r - size_ow;
              out_valid_r <= 1'b1;
              out_item_r  <= make_out(KIND_ALLOC, tail_ext[31:0], '0, ST_OK, 1'b1);
              state_r     <= S_IDLE;
            end else begin
              // wrap the tail to the end of the fixed block
              tail_r  <= fixed_size;
              free_r  <= wrap_free;
              state_r <= S_EQ;
            end
          end
          S_EQ: begin
            if (head_r == tail_r) begin
              if (q_empty) begin
                out_valid_r <= 1'b1;
                out_item_r  <= make_out(KIND_ALLOC, '0, '0, ST_NO_MEM, 1'b1);
                state_r     <= S_IDLE;
              end else begin
                ret_lt_r <= 1'b1;
                state_r  <= S_POP_RD;
              end
            end else begin
              state_r <= S_LT;
            end
          end
          S_LT: begin
            if (tail_r < head_r) begin
              free_r  <= head_r - tail_r;
              state_r <= S_LTFIT;
            end else begin
              state_r <= S_END;
            end
          end
          S_LTFIT: begin
            if (fits) begin
              tail_r      <= tail_r + size_ow;
              free_r      <= free_r - size_ow;
              out_valid_r <= 1'b1;
              out_item_r  <= make_out(KIND_ALLOC, tail_ext[31:0], '0, ST_OK, 1'b1);
              state_r     <= S_IDLE;
            end else if (q_empty) begin
              out_valid_r <= 1'b1;
              out_item_r  <= make_out(KIND_ALLOC, '0, '0, ST_NO_MEM, 1'b1);
              state_r     <= S_IDLE;
            end else begin
              ret_lt_r <= 1'b0;
              state_r  <= S_POP_RD;
            end
          end
          S_END: begin
            if (popped_r) begin
              state_r <= S_TOP;
            end else begin
              out_valid_r <= 1'b1;
              out_item_r  <= make_out(KIND_ALLOC, '0, '0, ST_NO_MEM, 1'b1);
              state_r     <= S_IDLE;
            end
          end
          S_POP_RD: begin
            state_r <= S_POP_WAIT;
          end
          S_POP_WAIT: begin
            // advance the head to the oldest marker and report its fence
            head_r      <= pop_off;
            rd_ptr_r    <= rd_ptr_inc;
            cnt_r       <= cnt_r - 1'b1;
            popped_r    <= 1'b1;
            out_valid_r <= 1'b1;
            out_item_r  <= make_out(KIND_WAIT, '0, mem_rd_data[FENCE_W-1:0], ST_OK, 1'b0);
            state_r     <= ret_lt_r ? S_LT : S_TOP;
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  // Marker count never passes the queue depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(MD))
    else $error("marker count beyond depth");

  // A marker is only read while the queue holds one
  a_rd_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd_en |-> !q_empty)
    else $error("marker read from empty queue");

  // A marker is only stored while the queue has room
  a_wr_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> !q_full)
    else $error("marker stored into full queue");

  // A wait result is never the final result of an item
  a_wait_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.kind == KIND_WAIT) |-> !out_item_r.last)
    else $error("wait result flagged last");

  // Each pop consumes exactly one marker
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_WAIT && out_free) |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("pop did not consume a marker");

endmodule

// File: src/fenced_ring_buffer_allocator_core.sv
// Top level of the fenced ring buffer allocator: configuration registers and sequencer.
// Usage
//   in_*  : requests. action 0 allocates request_size bytes, action 1 marks the end
//           of a frame with frame_fence. An item is taken when in_valid and in_ready
//           are both high; in_ready is high whenever the sequencer is idle.
//   out_* : results, one or more per request, the final one with last set. An
//           allocation emits one wait-for-fence result per marker popped, then the
//           allocation result. A mark emits one acknowledge.
//   cfg_* : buffer_size (index 0) and fixed_block_size (index 1), written while idle.
// Sequencing
//   One request in work at a time. A mark, or an allocation that fits at once, is taken
//   in S_IDLE and has its result registered from S_MARK or S_ALLOC; the wrap and
//   free-space checks add the states S_TOP, S_ENDFIT, S_EQ, S_LT, S_LTFIT and S_END.
//   Each popped marker is read from the marker store in S_POP_RD and S_POP_WAIT,
//   ending with its wait result, and the checks then follow again.
// Reset
//   Synchronous, active low: registers go to 65536 and 0, head and tail to 0, the
//   marker queue empties. The marker store is not cleared; only stored entries are read.
// Stall
//   A result waits in the output register while out_ready is low; the sequencer
//   holds until it is taken, and the next request is still taken once idle.
module fenced_ring_buffer_allocator_core import frba_pkg::*; #(
  parameter int MARKER_DEPTH = MARKER_DEPTH_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_we,
  input  logic             cfg_idx,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int OW = OFFSET_WIDTH;
  localparam int CW = (OW > CFG_W) ? OW : CFG_W;

  logic [OW-1:0] buf_size_r, fixed_size_r;
  logic [CW-1:0] wdata_ext;

  assign wdata_ext = CW'(cfg_wdata);

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_size_r   <= OW'(RST_BUFFER_SIZE);
      fixed_size_r <= OW'(RST_FIXED_SIZE);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_BUFFER_SIZE:      buf_size_r   <= wdata_ext[OW-1:0];
        CFG_FIXED_BLOCK_SIZE: fixed_size_r <= wdata_ext[OW-1:0];
        default:              ;
      endcase
    end
  end

  frba_seq #(
    .MARKER_DEPTH (MARKER_DEPTH),
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .buf_size   (buf_size_r),
    .fixed_size (fixed_size_r),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

// File: dv/ring_ledger_pkg.sv
// Shadow of the fenced ring allocator that predicts and checks its result items.
package ring_ledger_pkg;
  import frba_pkg::*;

  localparam int MARKS = MARKER_DEPTH_DEF;

  typedef logic [OFFSET_WIDTH_DEF-1:0] offs_t;

  class ring_ledger;
    // Register copies
    offs_t           buf_size;
    offs_t           fixed_size;
    // Ring state
    offs_t           head;
    offs_t           tail;
    offs_t           free_bytes;
    bit              tail_moved;
    offs_t           mark_off [MARKS];
    logic [63:0]     mark_fence [MARKS];
    int unsigned     rd_ptr;
    int unsigned     mark_cnt;
    // Result items still owed by the block, oldest first
    out_item_t       owed_results [$];
    int unsigned     mismatches;

    function new();
      buf_size   = RST_BUFFER_SIZE[OFFSET_WIDTH_DEF-1:0];
      fixed_size = RST_FIXED_SIZE[OFFSET_WIDTH_DEF-1:0];
      head       = fixed_size;
      tail       = fixed_size;
      free_bytes = (buf_size >= fixed_size) ? buf_size - fixed_size : '0;
      tail_moved = 1'b0;
      rd_ptr     = 0;
      mark_cnt   = 0;
      mismatches = 0;
    endfunction

    function void set_register(logic idx, logic [CFG_W-1:0] value);
      if (idx == CFG_BUFFER_SIZE) begin
        buf_size = value;
      end else begin
        fixed_size = value;
      end
    endfunction

    function void owe(logic [1:0] kind, offs_t off, logic [63:0] fence, logic [1:0] st,
                      logic fin);
      out_item_t owed;
      owed = out_item_t'{kind: kind, block_offset: off, wait_fence: fence,
                         status: st, last: fin};
      owed_results.insert(owed_results.size(), owed);
    endfunction

    // Hand out the block at the tail and advance it
    function void grant(offs_t size);
      owe(KIND_ALLOC, tail, '0, ST_OK, 1'b1);
      tail       = tail + size;
      free_bytes = free_bytes - size;
    endfunction

    // Advance the head to the oldest frame marker and owe its fence wait
    function void retire_marker();
      head = mark_off[rd_ptr];
      owe(KIND_WAIT, '0, mark_fence[rd_ptr], ST_OK, 1'b0);
      rd_ptr   = (rd_ptr + 1) % MARKS;
      mark_cnt = mark_cnt - 1;
    endfunction

    function void predict_allocate(offs_t size);
      bit done;
      bit popped;
      done       = 1'b0;
      tail_moved = 1'b1;
      if (size <= free_bytes) begin
        grant(size);
        done = 1'b1;
      end
      while (!done) begin
        popped = 1'b0;
        // Try the space left at the end, else wrap to the end of the fixed block
        if (tail > head) begin
          free_bytes = (tail >= buf_size) ? '0 : buf_size - tail;
          if (size <= free_bytes) begin
            grant(size);
            done = 1'b1;
          end else begin
            tail       = fixed_size;
            free_bytes = (head >= tail) ? head - tail : '0;
          end
        end
        if (!done && head == tail) begin
          if (mark_cnt == 0) begin
            owe(KIND_ALLOC, '0, '0, ST_NO_MEM, 1'b1);
            done = 1'b1;
          end else begin
            retire_marker();
            popped = 1'b1;
          end
        end
        if (!done && tail < head) begin
          free_bytes = head - tail;
          if (size <= free_bytes) begin
            grant(size);
            done = 1'b1;
          end else if (mark_cnt == 0) begin
            owe(KIND_ALLOC, '0, '0, ST_NO_MEM, 1'b1);
            done = 1'b1;
          end else begin
            retire_marker();
            popped = 1'b1;
          end
        end
        // No way forward: head sits below the wrapped tail
        if (!done && !popped) begin
          owe(KIND_ALLOC, '0, '0, ST_NO_MEM, 1'b1);
          done = 1'b1;
        end
      end
    endfunction

    function void predict_mark(logic [63:0] fence);
      int unsigned wr;
      if (!tail_moved) begin
        owe(KIND_MARK, '0, '0, ST_SKIPPED, 1'b1);
      end else if (mark_cnt >= MARKS) begin
        owe(KIND_MARK, '0, '0, ST_Q_FULL, 1'b1);
      end else begin
        wr             = (rd_ptr + mark_cnt) % MARKS;
        mark_off[wr]   = tail;
        mark_fence[wr] = fence;
        mark_cnt       = mark_cnt + 1;
        tail_moved     = 1'b0;
        owe(KIND_MARK, '0, '0, ST_OK, 1'b1);
      end
    endfunction

    function void note_request(in_item_t req);
      if (req.action == ACT_ALLOC) begin
        predict_allocate(req.request_size);
      end else begin
        predict_mark(req.frame_fence);
      end
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        $error("result item with none owed: kind %0d status %0d", got.kind, got.status);
        mismatches++;
        return;
      end
      want = owed_results[0];
      owed_results.delete(0);
      check_field("kind", want.kind, got.kind);
      check_field("block_offset", want.block_offset, got.block_offset);
      check_field("wait_fence", want.wait_fence, got.wait_fence);
      check_field("status", want.status, got.status);
      check_field("last", want.last, got.last);
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
// Top of the allocator testbench: clock, reset, request and result drivers, stimulus.
module tb_top;
  import frba_pkg::*;
  import ring_ledger_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 40;
  localparam int QUIET_LIMIT   = 2000;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_SHUT} rx_mode_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_item;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  ring_ledger       ledger;
  int unsigned      burst_left;
  logic [63:0]      fence_seq;
  rx_mode_t         stall_mode = RX_OPEN;
  int unsigned      stall_left = 0;
  int unsigned      quiet_cycles = 0;

  fenced_ring_buffer_allocator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Receiver: stretches of open, coin-toss, sparse and shut ready
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_left = (stall_mode == RX_SHUT) ? $urandom_range(1, 20) : $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_mode)
      RX_OPEN:   out_ready = 1'b1;
      RX_COIN:   out_ready = 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
      default:   out_ready = 1'b0;
    endcase
  end

  // Check every result item taken
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      ledger.check_result(out_item);
    end
  end

  // Give up when neither channel has moved an item for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one request, hold it until taken, then maybe drop valid for a gap
  task automatic offer_request(input in_item_t req);
    @(negedge clk);
    in_valid = 1'b1;
    in_item  = req;
    do begin
      @(posedge clk);
    end while (!in_ready);
    ledger.note_request(req);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  task automatic alloc_req(input logic [SIZE_W-1:0] size);
    offer_request(in_item_t'{action: ACT_ALLOC, request_size: size,
                             frame_fence: {$urandom, $urandom}});
  endtask

  task automatic mark_req(input logic [FENCE_W-1:0] fence);
    offer_request(in_item_t'{action: ACT_MARK, request_size: $urandom, frame_fence: fence});
  endtask

  // Drop valid and wait until every owed result has been taken
  task automatic await_idle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (ledger.owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    ledger.set_register(idx, value);
  endtask

  task automatic reconfigure(input logic [CFG_W-1:0] bsize, input logic [CFG_W-1:0] fsize);
    await_idle();
    write_register(CFG_BUFFER_SIZE, bsize);
    write_register(CFG_FIXED_BLOCK_SIZE, fsize);
  endtask

  // Mostly small sizes; now and then zero, the whole region or beyond the range
  function automatic logic [SIZE_W-1:0] pick_size(int unsigned span, int unsigned span_div,
                                                  int unsigned odds);
    int unsigned roll;
    roll = $urandom_range(0, odds);
    case (roll)
      0:       return '0;
      1:       return span;
      2:       return $urandom;
      3:       return '1;
      default: return $urandom_range(1, span / span_div + 1);
    endcase
  endfunction

  task automatic run_phase(input logic [CFG_W-1:0] bsize, input logic [CFG_W-1:0] fsize,
                           input int unsigned span_div, input int unsigned odds,
                           input int unsigned n_items, input bit stack_frames);
    int unsigned span;
    int unsigned sent;
    int unsigned allocs;
    int unsigned roll;
    reconfigure(bsize, fsize);
    span = (bsize > fsize) ? bsize - fsize : 32'd256;
    sent = 0;
    // Stack frames past a full marker queue, then ask for the whole range so
    // that every stored marker is popped by one request
    if (stack_frames) begin
      repeat (MARKS + 4) begin
        alloc_req($urandom_range(0, 1 << 20));
        fence_seq += $urandom_range(1, 9);
        mark_req(fence_seq);
      end
      alloc_req('1);
      sent = 2 * (MARKS + 4) + 1;
    end
    while (sent < n_items) begin
      roll = $urandom_range(0, 9);
      if (roll < 8) begin
        // Well-formed frame: a few allocations closed by a mark
        allocs = $urandom_range(1, 4);
        repeat (allocs) alloc_req(pick_size(span, span_div, odds));
        fence_seq += $urandom_range(1, 9);
        mark_req(fence_seq);
        sent += allocs + 1;
      end else if (roll == 8) begin
        offer_request(in_item_t'{action: 1'($urandom_range(0, 1)), request_size: $urandom,
                                 frame_fence: {$urandom, $urandom}});
        sent++;
      end else begin
        // Broken frame: mark twice with nothing between, then overreach the region
        fence_seq += 1;
        mark_req(fence_seq);
        mark_req(fence_seq + 1);
        alloc_req(span + $urandom_range(1, 64));
        sent += 3;
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = CFG_BUFFER_SIZE;
    cfg_wdata  = '0;
    burst_left = 0;
    fence_seq  = {$urandom, 32'h0};
    ledger     = new();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Skipped and stored marks, a wrap that pops a marker, refusal on an empty queue
    mark_req('1);
    alloc_req('0);
    alloc_req(32'd40000);
    mark_req(64'd1);
    mark_req(64'd2);
    alloc_req(32'd20000);
    mark_req(64'd3);
    alloc_req(32'd10000);
    alloc_req('1);
    mark_req(64'h8000_0000_0000_0004);
    // Shrink the ring below the tail: the space at the end counts as nothing
    reconfigure(32'd12000, 32'd0);
    alloc_req(32'd5000);
    mark_req(64'd5);
    alloc_req(32'd60000);
    // Reserve a fixed block above the head so that a wrap cannot make progress
    reconfigure(32'd65536, 32'd20000);
    alloc_req(32'd5000);
    mark_req(64'd6);
    alloc_req(32'd10000);
    alloc_req(32'd60000);

    // Random frames under several ring shapes, the extremes among them
    run_phase(32'hFFFF_FFFF, 32'd0, 4096, 99, 80, 1'b1);
    run_phase(32'd65536, 32'd0, 8, 19, 70, 1'b0);
    run_phase(32'd4096, 32'd256, 6, 19, 70, 1'b0);
    run_phase(32'd0, 32'hFFFF_FFFF, 4, 9, 20, 1'b0);
    run_phase(32'd1024, 32'd1000, 2, 19, 40, 1'b0);
    run_phase(32'd8192, 32'd0, 6, 19, 100, 1'b0);

    await_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.owed_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/frba_pkg.sv
src/frba_marker_mem.sv
src/frba_seq.sv
src/fenced_ring_buffer_allocator_core.sv
dv/ring_ledger_pkg.sv
dv/tb_top.sv
